// ===== rtl/kvt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package kvt_pkg;

    localparam int DEF_CAPACITY   = 256;
    localparam int DEF_KEY_BITS   = 32;
    localparam int DEF_VALUE_BITS = 64;

    typedef enum logic [2:0] {
        OP_INSERT           = 3'd0,
        OP_UPDATE           = 3'd1,
        OP_INSERT_OR_UPDATE = 3'd2,
        OP_ERASE            = 3'd3,
        OP_CONTAINS         = 3'd4,
        OP_GET_BY_KEY       = 3'd5,
        OP_GET_BY_INDEX     = 3'd6,
        OP_SIZE             = 3'd7
    } op_t;

    typedef struct packed {
        logic live;
        logic hit;
        logic app;
    } scan_flags_t;

endpackage

`default_nettype wire

// ===== rtl/kvt_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface kvt_in_if #(
    parameter int KB = 32,
    parameter int VB = 64,
    parameter int CB = 9
);
    logic          valid;
    logic          ready;
    logic [2:0]    action;
    logic [KB-1:0] key;
    logic [VB-1:0] value;
    logic [CB-1:0] position;

    modport source (output valid, action, key, value, position, input ready);
    modport sink   (input valid, action, key, value, position, output ready);
endinterface

interface kvt_out_if #(
    parameter int KB = 32,
    parameter int VB = 64,
    parameter int CB = 9
);
    logic          valid;
    logic          ready;
    logic          ok;
    logic [KB-1:0] found_key;
    logic [VB-1:0] found_value;
    logic [CB-1:0] entry_count;

    modport source (output valid, ok, found_key, found_value, entry_count, input ready);
    modport sink   (input valid, ok, found_key, found_value, entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/kvt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kvt_cell #(
    parameter int IDX = 0,
    parameter int KB  = 32,
    parameter int VB  = 64,
    parameter int CB  = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  kvt_pkg::op_t         act,
    input  wire [KB-1:0]         req_key,
    input  wire [VB-1:0]         req_value,
    input  wire [CB-1:0]         req_pos,
    input  wire [CB-1:0]         req_cnt,
    input  kvt_pkg::scan_flags_t flg_in,
    input  wire [KB-1:0]         fk_in,
    input  wire [VB-1:0]         fv_in,
    input  wire [KB-1:0]         nxt_key,
    input  wire [VB-1:0]         nxt_value,
    output logic [KB-1:0]        own_key,
    output logic [VB-1:0]        own_value,
    output kvt_pkg::scan_flags_t flg_out,
    output logic [KB-1:0]        fk_out,
    output logic [VB-1:0]        fv_out
);
    import kvt_pkg::*;

    localparam logic [CB-1:0] MY_POS = CB'(IDX);

    scan_flags_t   flg_reg;
    logic [KB-1:0] fk_reg;
    logic [VB-1:0] fv_reg;
    logic [KB-1:0] key_reg;
    logic [KB-1:0] key_next;
    logic [VB-1:0] value_reg;
    logic [VB-1:0] value_next;

    logic occ;
    logic key_hit;
    logic pos_hit;
    logic sel_hit;
    logic tail;
    logic shift;
    logic upd;
    logic is_get;

    always_comb
    begin
        occ     = (MY_POS < req_cnt);
        key_hit = flg_reg.live && occ && (key_reg == req_key) && !flg_reg.hit;
        pos_hit = flg_reg.live && occ && (MY_POS == req_pos);
        sel_hit = (act == OP_GET_BY_INDEX) ? pos_hit : key_hit;
        is_get  = (act == OP_GET_BY_KEY) || (act == OP_GET_BY_INDEX);
        tail    = flg_reg.live && (MY_POS == req_cnt) && !flg_reg.hit
                  && ((act == OP_INSERT) || (act == OP_INSERT_OR_UPDATE));
        shift   = flg_reg.live && occ && (act == OP_ERASE) && (flg_reg.hit || key_hit);
        upd     = key_hit && ((act == OP_UPDATE) || (act == OP_INSERT_OR_UPDATE));

        flg_out.live = flg_reg.live;
        flg_out.hit  = flg_reg.hit || sel_hit;
        flg_out.app  = flg_reg.app || tail;
        fk_out = (pos_hit && (act == OP_GET_BY_INDEX)) ? key_reg : fk_reg;
        fv_out = (sel_hit && is_get) ? value_reg : fv_reg;

        key_next   = key_reg;
        value_next = value_reg;
        priority if (tail)
        begin
            key_next   = req_key;
            value_next = req_value;
        end
        else if (shift)
        begin
            key_next   = nxt_key;
            value_next = nxt_value;
        end
        else if (upd)
        begin
            value_next = req_value;
        end
        else
        begin
            key_next   = key_reg;
            value_next = value_reg;
        end
    end

    assign own_key   = key_reg;
    assign own_value = value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flg_reg <= '0;
        end
        else
        begin
            flg_reg <= flg_in;
        end
    end

    always_ff @(posedge clk)
    begin
        fk_reg    <= fk_in;
        fv_reg    <= fv_in;
        key_reg   <= key_next;
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/kvt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module kvt_ctrl #(
    parameter int KB = 32,
    parameter int VB = 64,
    parameter int CB = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    kvt_in_if.sink               in_ch,
    kvt_out_if.source            out_ch,
    output kvt_pkg::op_t         act,
    output logic [KB-1:0]        req_key,
    output logic [VB-1:0]        req_value,
    output logic [CB-1:0]        req_pos,
    output logic [CB-1:0]        req_cnt,
    output kvt_pkg::scan_flags_t inj_flg,
    input  kvt_pkg::scan_flags_t exit_flg,
    input  wire [KB-1:0]         exit_fk,
    input  wire [VB-1:0]         exit_fv
);
    import kvt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_WAIT = 3'b100
    } state_t;

    state_t        state_reg;
    state_t        state_next;
    op_t           act_reg;
    logic [KB-1:0] key_reg;
    logic [VB-1:0] value_reg;
    logic [CB-1:0] pos_reg;
    logic [CB-1:0] cnt_reg;
    logic [CB-1:0] cnt_next;
    logic          inj_reg;
    logic          inj_next;
    logic          res_ok_reg;
    logic          res_ok_next;
    logic [KB-1:0] res_fk_reg;
    logic [VB-1:0] res_fv_reg;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_ok_reg;
    logic [KB-1:0] out_fk_reg;
    logic [VB-1:0] out_fv_reg;
    logic [CB-1:0] out_cnt_reg;
    logic          accept;
    logic          load_out;
    logic          scan_done;

    assign in_ch.ready = (state_reg == ST_IDLE);
    assign accept      = in_ch.valid && in_ch.ready;
    assign scan_done   = (state_reg == ST_SCAN) && exit_flg.live;
    assign load_out    = (state_reg == ST_WAIT) && (!out_valid_reg || out_ch.ready);

    assign act       = act_reg;
    assign req_key   = key_reg;
    assign req_value = value_reg;
    assign req_pos   = pos_reg;
    assign req_cnt   = cnt_reg;
    assign inj_flg   = '{live: inj_reg, hit: 1'b0, app: 1'b0};

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.ok          = out_ok_reg;
    assign out_ch.found_key   = out_fk_reg;
    assign out_ch.found_value = out_fv_reg;
    assign out_ch.entry_count = out_cnt_reg;

    always_comb
    begin
        unique case (act_reg)
            OP_INSERT:           res_ok_next = exit_flg.app;
            OP_INSERT_OR_UPDATE: res_ok_next = exit_flg.hit || exit_flg.app;
            OP_SIZE:             res_ok_next = 1'b1;
            default:             res_ok_next = exit_flg.hit;
        endcase

        cnt_next = cnt_reg;
        if (scan_done)
        begin
            priority if (exit_flg.app)
                cnt_next = cnt_reg + CB'(1);
            else if ((act_reg == OP_ERASE) && exit_flg.hit)
                cnt_next = cnt_reg - CB'(1);
            else
                cnt_next = cnt_reg;
        end

        inj_next   = accept;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SCAN;
            ST_SCAN: if (scan_done) state_next = ST_WAIT;
            ST_WAIT: if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        priority if (load_out)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            inj_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            inj_reg       <= inj_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg   <= op_t'(in_ch.action);
            key_reg   <= in_ch.key;
            value_reg <= in_ch.value;
            pos_reg   <= in_ch.position;
        end
        if (scan_done)
        begin
            res_ok_reg <= res_ok_next;
            res_fk_reg <= exit_fk;
            res_fv_reg <= exit_fv;
        end
        if (load_out)
        begin
            out_ok_reg  <= res_ok_reg;
            out_fk_reg  <= res_fk_reg;
            out_fv_reg  <= res_fv_reg;
            out_cnt_reg <= cnt_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/fixed_capacity_key_value_table_core.sv =====
// Fixed-capacity key/value table, entries kept in insertion order.
// in_ch carries one request transaction: action, key, value, position.
// out_ch returns one result transaction per request: ok, found_key,
// found_value and entry_count after the action.
// The table is a chain of CAPACITY cells. An accepted request sends a scan
// token down the chain, one cell per cycle, which matches keys, rewrites
// values, appends at the tail and shifts entries down on erase as it passes.
// The result reaches out_ch.valid only once the token has traversed every
// cell of the chain and passed through the result and output registers.
// No request is accepted before the previous scan is done; in_ch.ready is high
// only while no scan runs or waits for the output register.
// A stalled receiver holds the finished result in the output register; the
// next request is accepted meanwhile, and its result waits until the
// previous one is taken.
// Reset clears the entry count and all scan control; stored keys and values
// are not cleared and are only read below the count.
`timescale 1ns / 1ps
`default_nettype none

module fixed_capacity_key_value_table_core #(
    parameter int CAPACITY   = kvt_pkg::DEF_CAPACITY,
    parameter int KEY_BITS   = kvt_pkg::DEF_KEY_BITS,
    parameter int VALUE_BITS = kvt_pkg::DEF_VALUE_BITS
) (
    input  wire       clk,
    input  wire       rst_n,
    kvt_in_if.sink    in_ch,
    kvt_out_if.source out_ch
);
    import kvt_pkg::*;

    localparam int CB = $clog2(CAPACITY + 1);

    op_t             act;
    logic [KEY_BITS-1:0]   req_key;
    logic [VALUE_BITS-1:0] req_value;
    logic [CB-1:0]         req_pos;
    logic [CB-1:0]         req_cnt;

    scan_flags_t           flg_chain [CAPACITY+1];
    logic [KEY_BITS-1:0]   fk_chain  [CAPACITY+1];
    logic [VALUE_BITS-1:0] fv_chain  [CAPACITY+1];
    logic [KEY_BITS-1:0]   cell_key  [CAPACITY];
    logic [VALUE_BITS-1:0] cell_value[CAPACITY];

    assign fk_chain[0] = '0;
    assign fv_chain[0] = '0;

    kvt_ctrl #(
        .KB (KEY_BITS),
        .VB (VALUE_BITS),
        .CB (CB)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .act       (act),
        .req_key   (req_key),
        .req_value (req_value),
        .req_pos   (req_pos),
        .req_cnt   (req_cnt),
        .inj_flg   (flg_chain[0]),
        .exit_flg  (flg_chain[CAPACITY]),
        .exit_fk   (fk_chain[CAPACITY]),
        .exit_fv   (fv_chain[CAPACITY])
    );

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   nxt_key;
        logic [VALUE_BITS-1:0] nxt_value;

        if (i == CAPACITY - 1)
        begin : g_last
            assign nxt_key   = cell_key[i];
            assign nxt_value = cell_value[i];
        end
        else
        begin : g_mid
            assign nxt_key   = cell_key[i+1];
            assign nxt_value = cell_value[i+1];
        end

        kvt_cell #(
            .IDX (i),
            .KB  (KEY_BITS),
            .VB  (VALUE_BITS),
            .CB  (CB)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .act       (act),
            .req_key   (req_key),
            .req_value (req_value),
            .req_pos   (req_pos),
            .req_cnt   (req_cnt),
            .flg_in    (flg_chain[i]),
            .fk_in     (fk_chain[i]),
            .fv_in     (fv_chain[i]),
            .nxt_key   (nxt_key),
            .nxt_value (nxt_value),
            .own_key   (cell_key[i]),
            .own_value (cell_value[i]),
            .flg_out   (flg_chain[i+1]),
            .fk_out    (fk_chain[i+1]),
            .fv_out    (fv_chain[i+1])
        );
    end

endmodule

`default_nettype wire
